// ----- rtl/qmi_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qmi_pkg
// Shared types and constants for the queue with middle insert.
// ----------------------------------------------------------------------------
package qmi_pkg;

  localparam int unsigned DEPTH_DEF      = 1024;
  localparam int unsigned DATA_WIDTH_DEF = 32;

  // Position bus wide enough for the largest supported depth
  localparam int unsigned POS_W = 17;

  typedef enum logic [1:0] {
    OP_PUSH   = 2'd0,
    OP_POP    = 2'd1,
    OP_INSERT = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    logic             shl;
    logic             ins;
    logic [POS_W-1:0] pos;
  } cell_ctrl_t;

endpackage
`default_nettype wire

// ----- rtl/qmi_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qmi_cell
// One queue slot: hold, take from left or right neighbor, or load new data.
// ----------------------------------------------------------------------------
module qmi_cell
  import qmi_pkg::*;
#(
  parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int unsigned IDX        = 0
) (
  input  wire logic                  clk,
  input  wire cell_ctrl_t            ctrl,
  input  wire logic [DATA_WIDTH-1:0] left_d,
  input  wire logic [DATA_WIDTH-1:0] right_d,
  input  wire logic [DATA_WIDTH-1:0] load_d,
  output logic      [DATA_WIDTH-1:0] q
);

  localparam logic [POS_W-1:0] MY_POS = POS_W'(IDX);

  logic [DATA_WIDTH-1:0] q_r;
  logic [DATA_WIDTH-1:0] q_nxt;

  always_comb begin
    q_nxt = q_r;
    priority if (ctrl.shl) begin
      q_nxt = right_d;
    end else if (ctrl.ins && (ctrl.pos == MY_POS)) begin
      q_nxt = load_d;
    end else if (ctrl.ins && (MY_POS > ctrl.pos)) begin
      q_nxt = left_d;
    end else begin
      q_nxt = q_r;
    end
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

  assign q = q_r;

endmodule
`default_nettype wire

// ----- rtl/queue_with_middle_insert.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// queue_with_middle_insert
// Bounded queue with push at tail, pop at head and insert at position
// ceil(n/2), built as a row of slot cells.
// ----------------------------------------------------------------------------
// Entries sit in order in a row of DEPTH cells, head in cell 0. A pop shifts
// every cell one place toward the head; a push loads the cell at the count;
// an insert loads the cell at ceil(n/2) and shifts the cells behind it one
// place toward the tail. Every cell updates in the same clock, so one
// transaction is taken per cycle when not stalled and its result appears in
// the output register on the next cycle. A push or insert on a full queue is
// dropped with status full, a pop on an empty queue reports status empty with
// a zero value, and op code 3 changes nothing and reports ok.
// ----------------------------------------------------------------------------
module queue_with_middle_insert
  import qmi_pkg::*;
#(
  parameter int unsigned DEPTH      = DEPTH_DEF,
  parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF,
  localparam int unsigned CNT_W     = $clog2(DEPTH + 1)
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic        [1:0]            in_op,
  input  wire logic signed [DATA_WIDTH-1:0] in_value,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic signed      [DATA_WIDTH-1:0] out_popped_value,
  output logic             [1:0]            out_status,
  output logic             [CNT_W-1:0]      out_count
);

  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  logic                  acc;
  logic [CNT_W-1:0]      cnt_r;
  logic [CNT_W-1:0]      cnt_nxt;
  logic [CNT_W:0]        cnt_inc;
  logic [CNT_W-1:0]      mid_pos;
  cell_ctrl_t            ctrl;
  status_t               status_nxt;
  logic [DATA_WIDTH-1:0] popped_nxt;

  logic                  out_valid_r;
  logic                  out_valid_nxt;
  logic [DATA_WIDTH-1:0] out_popped_r;
  logic [1:0]            out_status_r;
  logic [CNT_W-1:0]      out_count_r;

  logic [DATA_WIDTH-1:0] slot_q [DEPTH];

  assign in_ready = !out_valid_r || out_ready;
  assign acc      = in_valid && in_ready;
  assign cnt_inc  = {1'b0, cnt_r} + {{CNT_W{1'b0}}, 1'b1};
  assign mid_pos  = cnt_inc[CNT_W:1];

  always_comb begin
    ctrl       = '0;
    cnt_nxt    = cnt_r;
    status_nxt = ST_OK;
    popped_nxt = '0;
    if (acc) begin
      unique case (op_t'(in_op))
        OP_PUSH: begin
          if (cnt_r == FULL_CNT) begin
            status_nxt = ST_FULL;
          end else begin
            ctrl.ins = 1'b1;
            ctrl.pos = POS_W'(cnt_r);
            cnt_nxt  = cnt_inc[CNT_W-1:0];
          end
        end
        OP_INSERT: begin
          if (cnt_r == FULL_CNT) begin
            status_nxt = ST_FULL;
          end else begin
            ctrl.ins = 1'b1;
            ctrl.pos = POS_W'(mid_pos);
            cnt_nxt  = cnt_inc[CNT_W-1:0];
          end
        end
        OP_POP: begin
          if (cnt_r == '0) begin
            status_nxt = ST_EMPTY;
          end else begin
            ctrl.shl   = 1'b1;
            popped_nxt = slot_q[0];
            cnt_nxt    = cnt_r - {{(CNT_W-1){1'b0}}, 1'b1};
          end
        end
        default: begin
          status_nxt = ST_OK;
        end
      endcase
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (acc) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      out_popped_r <= popped_nxt;
      out_status_r <= status_nxt;
      out_count_r  <= cnt_nxt;
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_slot
    logic [DATA_WIDTH-1:0] left_d;
    logic [DATA_WIDTH-1:0] right_d;

    if (i == 0) begin : g_first
      assign left_d = in_value;
    end else begin : g_left
      assign left_d = slot_q[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_d = '0;
    end else begin : g_right
      assign right_d = slot_q[i+1];
    end

    qmi_cell #(
      .DATA_WIDTH (DATA_WIDTH),
      .IDX        (i)
    ) u_cell (
      .clk     (clk),
      .ctrl    (ctrl),
      .left_d  (left_d),
      .right_d (right_d),
      .load_d  (in_value),
      .q       (slot_q[i])
    );
  end

  assign out_valid        = out_valid_r;
  assign out_popped_value = out_popped_r;
  assign out_status       = out_status_r;
  assign out_count        = out_count_r;

endmodule
`default_nettype wire

// ----- rtl/qmi_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qmi_checker
// Port-level checks for the queue with middle insert, bound to the top level.
// ----------------------------------------------------------------------------
module qmi_checker
  import qmi_pkg::*;
#(
  parameter int unsigned DEPTH      = DEPTH_DEF,
  parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF,
  localparam int unsigned CNT_W     = $clog2(DEPTH + 1)
) (
  input wire logic                         clk,
  input wire logic                         rst_n,
  input wire logic                         in_valid,
  input wire logic                         in_ready,
  input wire logic        [1:0]            in_op,
  input wire logic signed [DATA_WIDTH-1:0] in_value,
  input wire logic                         out_valid,
  input wire logic                         out_ready,
  input wire logic signed [DATA_WIDTH-1:0] out_popped_value,
  input wire logic        [1:0]            out_status,
  input wire logic        [CNT_W-1:0]      out_count
);

  a_out_hold : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_popped_value)
      && $stable(out_status) && $stable(out_count))
    else $error("result changed while stalled");

  a_in_result : assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("accepted transaction produced no result");

  a_full : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_FULL) |-> out_count == CNT_W'(DEPTH)
      && out_popped_value == '0)
    else $error("full status with count below depth");

  a_empty : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_EMPTY) |-> out_count == '0
      && out_popped_value == '0)
    else $error("empty status with entries held");

  a_count : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_count <= CNT_W'(DEPTH))
    else $error("count exceeds depth");

endmodule

bind queue_with_middle_insert qmi_checker #(
  .DEPTH      (DEPTH),
  .DATA_WIDTH (DATA_WIDTH)
) u_qmi_checker (.*);
`default_nettype wire

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Checks the queue with middle insert against a queue-based predictor. A
// directed table covers empty pops, the unused op code, insert on an empty
// queue and the value extremes. Random phases then mix all operations, grow
// the queue and drain it to empty while both handshakes idle and stall at
// random, and a final phase mixes all operations with no random stalls.
// ----------------------------------------------------------------------------
module tb_top;
  import qmi_pkg::*;

  localparam int unsigned QDEPTH   = DEPTH_DEF;
  localparam int unsigned CNT_W    = $clog2(DEPTH_DEF + 1);
  localparam int          N_DIR    = 25;
  localparam int          HOLD_AT  = 120;
  localparam int          HOLD_CYC = 64;
  localparam logic [1:0]  OP_UNUSED = 2'd3;

  typedef struct packed {
    logic signed [31:0] popped;
    status_t            status;
    logic [CNT_W-1:0]   count;
  } qresult_t;

  typedef struct packed {
    logic [1:0]         op;
    logic signed [31:0] value;
    logic               pinned;
    qresult_t           res;
  } vec_t;

  localparam qresult_t EMPTY_RES = '{32'sd0, ST_EMPTY, 11'd0};

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic [1:0]               in_op = OP_PUSH;
  logic signed [31:0]       in_value = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic signed [31:0]       out_popped_value;
  logic [1:0]               out_status;
  logic [CNT_W-1:0]         out_count;

  logic                     pin_on = 1'b0;
  qresult_t                 pin_res = '0;
  logic                     quiet = 1'b0;

  logic signed [31:0]       held [$];
  qresult_t                 exp_q [$];
  int                       n_taken = 0;
  int                       n_err = 0;
  int                       n_push = 0;
  int                       n_pop = 0;
  int                       n_ins = 0;
  int                       n_full = 0;
  int                       n_empty = 0;
  int                       peak = 0;

  vec_t dir_tab [N_DIR] = '{
    '{OP_POP,    32'sd0,        1'b1, EMPTY_RES},
    '{OP_UNUSED, 32'h0000_1234, 1'b1, '{32'sd0, ST_OK, 11'd0}},
    '{OP_INSERT, 32'h7fff_ffff, 1'b1, '{32'sd0, ST_OK, 11'd1}},
    '{OP_PUSH,   32'h8000_0000, 1'b1, '{32'sd0, ST_OK, 11'd2}},
    '{OP_INSERT, 32'hffff_ffff, 1'b1, '{32'sd0, ST_OK, 11'd3}},
    '{OP_PUSH,   32'sd0,        1'b0, '0},
    '{OP_INSERT, 32'sd5,        1'b0, '0},
    '{OP_UNUSED, 32'hffff_ffff, 1'b0, '0},
    '{OP_POP,    32'sd0,        1'b1, '{32'h7fff_ffff, ST_OK, 11'd4}},
    '{OP_POP,    32'sd0,        1'b0, '0},
    '{OP_POP,    32'sd0,        1'b0, '0},
    '{OP_POP,    32'hffff_ffff, 1'b0, '0},
    '{OP_POP,    32'sd0,        1'b0, '0},
    '{OP_POP,    32'sd0,        1'b1, EMPTY_RES},
    '{OP_PUSH,   32'sd1,        1'b0, '0},
    '{OP_PUSH,   32'sd2,        1'b0, '0},
    '{OP_INSERT, 32'sd3,        1'b0, '0},
    '{OP_INSERT, 32'sd4,        1'b0, '0},
    '{OP_POP,    32'sd0,        1'b0, '0},
    '{OP_POP,    32'sd0,        1'b0, '0},
    '{OP_POP,    32'sd0,        1'b0, '0},
    '{OP_POP,    32'sd0,        1'b0, '0},
    '{OP_POP,    32'sd0,        1'b1, EMPTY_RES},
    '{OP_INSERT, 32'ha5a5_a5a5, 1'b0, '0},
    '{OP_POP,    32'sd0,        1'b0, '0}
  };

  queue_with_middle_insert uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_op            (in_op),
    .in_value         (in_value),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_popped_value (out_popped_value),
    .out_status       (out_status),
    .out_count        (out_count)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  function automatic qresult_t apply_queue_op(input logic [1:0] op,
                                              input logic signed [31:0] v);
    qresult_t    r;
    int unsigned n;
    n = held.size();
    r = '{32'sd0, ST_OK, '0};
    case (op)
      OP_PUSH, OP_INSERT: begin
        if (n >= QDEPTH) begin
          r.status = ST_FULL;
        end else if (op == OP_PUSH) begin
          held.push_back(v);
        end else begin
          held.insert((n + 1) / 2, v);
        end
      end
      OP_POP: begin
        if (n == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.popped = held.pop_front();
        end
      end
      default: ;
    endcase
    r.count = CNT_W'(held.size());
    return r;
  endfunction

  task automatic flag_err(input string msg);
    n_err++;
    if (n_err <= 10) begin
      $display("[%0t] %s", $realtime, msg);
    end
  endtask

  always @(posedge clk) begin
    qresult_t want;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        want = apply_queue_op(in_op, in_value);
        if (pin_on) begin
          want = pin_res;
        end
        case (in_op)
          OP_PUSH:   n_push++;
          OP_POP:    n_pop++;
          OP_INSERT: n_ins++;
          default:   ;
        endcase
        if (want.status == ST_FULL) n_full++;
        if (want.status == ST_EMPTY) n_empty++;
        if (held.size() > peak) peak = held.size();
        exp_q.push_back(want);
        n_taken++;
      end
      if (out_valid && out_ready) begin
        if (exp_q.size() == 0) begin
          flag_err($sformatf("unexpected result popped=%0d status=%0d count=%0d",
                             out_popped_value, out_status, out_count));
        end else begin
          want = exp_q.pop_front();
          if (out_popped_value !== want.popped || out_status !== want.status ||
              out_count !== want.count) begin
            flag_err($sformatf(
              "mismatch exp popped=%0d status=%0d count=%0d, got %0d/%0d/%0d",
              want.popped, want.status, want.count,
              out_popped_value, out_status, out_count));
          end
        end
      end
    end
  end

  // Receiver: random stalls, plus one long hold once traffic is flowing
  initial begin
    bit hold_done;
    hold_done = 1'b0;
    forever begin
      @(negedge clk);
      if (rst_n && !hold_done && n_taken >= HOLD_AT) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYC) @(negedge clk);
        hold_done = 1'b1;
      end
      if (!quiet && $urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 4) - 1) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Call at a falling edge; returns at the falling edge after acceptance
  task automatic send(input logic [1:0] op, input logic signed [31:0] v,
                      input logic pin, input qresult_t pres);
    in_valid <= 1'b1;
    in_op    <= op;
    in_value <= v;
    pin_on   <= pin;
    pin_res  <= pres;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_random(input int push_w, input int pop_w, input int ins_w);
    int                 r;
    logic [1:0]         op;
    logic signed [31:0] v;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    r = $urandom_range(0, push_w + pop_w + ins_w + 1);
    if (r < push_w) op = OP_PUSH;
    else if (r < push_w + pop_w) op = OP_POP;
    else if (r < push_w + pop_w + ins_w) op = OP_INSERT;
    else op = OP_UNUSED;
    case ($urandom_range(0, 15))
      0:       v = 32'h8000_0000;
      1:       v = 32'h7fff_ffff;
      2:       v = 32'sd0;
      3:       v = -32'sd1;
      default: v = $urandom;
    endcase
    send(op, v, 1'b0, '0);
  endtask

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int k = 0; k < N_DIR; k++) begin
      send(dir_tab[k].op, dir_tab[k].value, dir_tab[k].pinned, dir_tab[k].res);
    end

    repeat (250) send_random(38, 30, 30);

    // hold off until the block has returned everything
    in_valid <= 1'b0;
    while (exp_q.size() != 0) @(posedge clk);
    @(negedge clk);

    repeat (150) send_random(48, 4, 46);
    while (held.size() != 0) send_random(4, 90, 4);
    repeat (4) send_random(0, 100, 0);

    quiet = 1'b1;
    repeat (200) send_random(35, 35, 28);

    in_valid <= 1'b0;
    while (exp_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Ran %0d transactions: %0d pushes, %0d inserts, %0d pops.",
             n_taken, n_push, n_ins, n_pop);
    $display("Full drops %0d, empty pops %0d, peak occupancy %0d, errors %0d.",
             n_full, n_empty, peak, n_err);
    if (n_err == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/qmi_pkg.sv
rtl/qmi_cell.sv
rtl/queue_with_middle_insert.sv
rtl/qmi_checker.sv
verif/tb_top.sv
